### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is asserted (active low).
`define SSF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SSF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SSF_ASSERT(label, clk, rst_n, prop, msg)
`define SSF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### src/ssf16_pkg.sv
// ----------------------------------------------------------------------------
// ssf16_pkg
// Constants, codes and helper functions of the sparse section scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ssf16_pkg;

    // Field widths of the channels.
    localparam int DATA_W    = 8;
    localparam int FIELD_W   = 32;
    localparam int CSUM_W    = 16;
    localparam int RUN_W     = 8;

    // Default width of the byte offset counter.
    localparam int OFFSET_BITS_DEFAULT = 32;

    // Fletcher-16 modulus and zero run saturation limit.
    localparam logic [DATA_W:0]  MOD     = 9'd255;
    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    // Reset value of the gap threshold register.
    localparam logic [RUN_W-1:0] MIN_ZERO_RUN_RESET = 8'd64;

    // Command codes of an input word.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Addition modulo 255 of two values that are each below 255.
    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= MOD) ? DATA_W'(s - MOD) : s[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/ssf16_channels.sv
// ----------------------------------------------------------------------------
// ssf16 channels
// Valid/ready interfaces for the byte input and the section report output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssf16_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [ssf16_pkg::DATA_W-1:0]   data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

interface ssf16_out_if;
    logic                           valid;
    logic                           ready;
    logic [ssf16_pkg::FIELD_W-1:0]  section_start;
    logic [ssf16_pkg::FIELD_W-1:0]  section_length;
    logic [ssf16_pkg::CSUM_W-1:0]   checksum;
    logic                           at_end;
    logic                           offset_overflow;

    modport source (output valid, section_start, section_length, checksum, at_end,
                    offset_overflow, input ready);
    modport sink   (input valid, section_start, section_length, checksum, at_end,
                    offset_overflow, output ready);
endinterface

`default_nettype wire

### src/sparse_section_fletcher16_scanner.sv
// ----------------------------------------------------------------------------
// sparse_section_fletcher16_scanner
// Splits a byte stream into non-sparse sections and reports each section's
// start, length and Fletcher-16 checksum.
// ----------------------------------------------------------------------------
// Usage:
// Bytes arrive as words on in_ch (command 0 = data byte, 1 = end of stream).
// A section report leaves as a word on out_ch when a gap of at least
// min_zero_run zero bytes is followed by a nonzero byte, or at end of a non-empty stream.
// The threshold is written through cfg_wr_en / cfg_wr_data while idle; it
// resets to 64 and a value of zero acts as one.
// Each word goes through an input register and then the sum and compare logic
// into the output register, from which its report is presented on out_ch. One
// word is taken every cycle unless a word that would report waits in the input register.
// If the receiver stalls, the output register holds its report; words that
// cause no report keep flowing, and a word that would report waits in the
// input register, which drops in_ch.ready until the output slot frees up.
// Reset clears all stream state and the valid flags of both registers; an end-of-stream word
// also returns the stream state to its reset values, keeping the threshold.
// The offset counter saturates at all ones and sets a sticky overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sparse_section_fletcher16_scanner #(
    parameter int OFFSET_BITS = ssf16_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ssf16_pkg::RUN_W-1:0]    cfg_wr_data,
    ssf16_in_if.sink                            in_ch,
    ssf16_out_if.source                         out_ch
);

    localparam int OB    = OFFSET_BITS;
    localparam int EXT_W = (OB > ssf16_pkg::FIELD_W) ? OB : ssf16_pkg::FIELD_W;
    localparam logic [OB-1:0] OFFSET_MAX = {OB{1'b1}};

    // Threshold register.
    logic [ssf16_pkg::RUN_W-1:0] min_zero_run_reg;

    // Input register.
    logic                          s1_valid_reg;
    logic                          s1_cmd_reg;
    logic [ssf16_pkg::DATA_W-1:0]  s1_byte_reg;

    // Stream state.
    logic [OB-1:0]                 byte_offset_reg, byte_offset_next;
    logic [OB-1:0]                 current_start_reg, current_start_next;
    logic [OB-1:0]                 gap_begin_reg, gap_begin_next;
    logic [ssf16_pkg::RUN_W-1:0]   zero_run_count_reg, zero_run_count_next;
    logic [ssf16_pkg::DATA_W-1:0]  low_sum_reg, low_sum_next;
    logic [ssf16_pkg::DATA_W-1:0]  high_sum_reg, high_sum_next;
    logic [ssf16_pkg::DATA_W-1:0]  shadow_high_sum_reg, shadow_high_sum_next;
    logic                          overflow_seen_reg, overflow_seen_next;

    // Output register.
    logic                          out_valid_reg;
    logic [ssf16_pkg::FIELD_W-1:0] out_start_reg;
    logic [ssf16_pkg::FIELD_W-1:0] out_length_reg;
    logic [ssf16_pkg::CSUM_W-1:0]  out_checksum_reg;
    logic                          out_at_end_reg;
    logic                          out_overflow_reg;

    // Report produced by the word in the input register.
    logic                          emit;
    logic [OB-1:0]                 emit_length;
    logic [ssf16_pkg::DATA_W-1:0]  emit_high;
    logic                          s1_adv;
    logic                          out_slot_free;
    logic [EXT_W-1:0]              start_ext;
    logic [EXT_W-1:0]              length_ext;

    // Handshake: the input register moves on unless its report is blocked.
    assign out_slot_free = !out_valid_reg || out_ch.ready;
    assign s1_adv        = s1_valid_reg && (!emit || out_slot_free);
    assign in_ch.ready   = !s1_valid_reg || s1_adv;

    // Threshold register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_zero_run_reg <= ssf16_pkg::MIN_ZERO_RUN_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_zero_run_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_cmd_reg  <= in_ch.command;
            s1_byte_reg <= in_ch.data_byte;
        end
    end

    // Section tracking and checksum update for one word.
    always_comb
    begin
        logic [ssf16_pkg::RUN_W-1:0]  thr;
        logic                         gap;
        logic [ssf16_pkg::DATA_W-1:0] low_base;
        logic [ssf16_pkg::DATA_W-1:0] high_base;
        logic [ssf16_pkg::DATA_W-1:0] shadow_base;
        logic [ssf16_pkg::DATA_W-1:0] low_new;

        thr         = (min_zero_run_reg == '0) ? ssf16_pkg::RUN_W'(1) : min_zero_run_reg;
        gap         = (zero_run_count_reg != '0) && (zero_run_count_reg >= thr);
        low_base    = low_sum_reg;
        high_base   = high_sum_reg;
        shadow_base = shadow_high_sum_reg;
        low_new     = low_sum_reg;

        byte_offset_next     = byte_offset_reg;
        current_start_next   = current_start_reg;
        gap_begin_next       = gap_begin_reg;
        zero_run_count_next  = zero_run_count_reg;
        low_sum_next         = low_sum_reg;
        high_sum_next        = high_sum_reg;
        shadow_high_sum_next = shadow_high_sum_reg;
        overflow_seen_next   = overflow_seen_reg;

        emit        = 1'b0;
        emit_length = '0;
        emit_high   = high_sum_reg;

        if (s1_cmd_reg == ssf16_pkg::CMD_END)
        begin
            // End of stream: report the last section, then clear the stream.
            if (gap)
            begin
                emit        = 1'b1;
                emit_length = gap_begin_reg - current_start_reg;
            end
            else
            begin
                if (zero_run_count_reg != '0)
                begin
                    emit_high = shadow_high_sum_reg;
                end
                if (current_start_reg != byte_offset_reg)
                begin
                    emit        = 1'b1;
                    emit_length = byte_offset_reg - current_start_reg;
                end
            end
            byte_offset_next     = '0;
            current_start_next   = '0;
            gap_begin_next       = '0;
            zero_run_count_next  = '0;
            low_sum_next         = '0;
            high_sum_next        = '0;
            shadow_high_sum_next = '0;
            overflow_seen_next   = 1'b0;
        end
        else
        begin
            if (s1_byte_reg != '0)
            begin
                // A nonzero byte closes a pending zero run.
                if (zero_run_count_reg != '0)
                begin
                    if (gap)
                    begin
                        emit               = 1'b1;
                        emit_length        = gap_begin_reg - current_start_reg;
                        low_base           = '0;
                        high_base          = '0;
                        current_start_next = byte_offset_reg;
                    end
                    else
                    begin
                        high_base = shadow_high_sum_reg;
                    end
                    zero_run_count_next = '0;
                end
                low_new              = ssf16_pkg::add_mod(low_base, s1_byte_reg);
                low_sum_next         = low_new;
                high_sum_next        = ssf16_pkg::add_mod(high_base, low_new);
                shadow_high_sum_next = ssf16_pkg::add_mod(high_base, low_new);
            end
            else
            begin
                // A zero byte extends the run; the shadow sum keeps it as data.
                if (zero_run_count_reg == '0)
                begin
                    gap_begin_next = byte_offset_reg;
                    shadow_base    = high_sum_reg;
                end
                if (zero_run_count_reg != ssf16_pkg::RUN_MAX)
                begin
                    zero_run_count_next = zero_run_count_reg + 1'b1;
                end
                shadow_high_sum_next = ssf16_pkg::add_mod(shadow_base, low_sum_reg);
            end

            // Saturating offset counter.
            if (byte_offset_reg == OFFSET_MAX)
            begin
                overflow_seen_next = 1'b1;
            end
            else
            begin
                byte_offset_next = byte_offset_reg + 1'b1;
            end
        end
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg     <= '0;
            current_start_reg   <= '0;
            gap_begin_reg       <= '0;
            zero_run_count_reg  <= '0;
            low_sum_reg         <= '0;
            high_sum_reg        <= '0;
            shadow_high_sum_reg <= '0;
            overflow_seen_reg   <= 1'b0;
        end
        else if (s1_adv)
        begin
            byte_offset_reg     <= byte_offset_next;
            current_start_reg   <= current_start_next;
            gap_begin_reg       <= gap_begin_next;
            zero_run_count_reg  <= zero_run_count_next;
            low_sum_reg         <= low_sum_next;
            high_sum_reg        <= high_sum_next;
            shadow_high_sum_reg <= shadow_high_sum_next;
            overflow_seen_reg   <= overflow_seen_next;
        end
    end

    // Offsets are reported in their low 32 bits.
    assign start_ext  = EXT_W'(current_start_reg);
    assign length_ext = EXT_W'(emit_length);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            out_start_reg    <= start_ext[ssf16_pkg::FIELD_W-1:0];
            out_length_reg   <= length_ext[ssf16_pkg::FIELD_W-1:0];
            out_checksum_reg <= {emit_high, low_sum_reg};
            out_at_end_reg   <= (s1_cmd_reg == ssf16_pkg::CMD_END);
            out_overflow_reg <= overflow_seen_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.section_start   = out_start_reg;
    assign out_ch.section_length  = out_length_reg;
    assign out_ch.checksum        = out_checksum_reg;
    assign out_ch.at_end          = out_at_end_reg;
    assign out_ch.offset_overflow = out_overflow_reg;

    // Sums stay reduced modulo 255.
    `SSF_ASSERT_ALWAYS(a_sums_reduced, clk,
        (low_sum_reg != 8'hFF) && (high_sum_reg != 8'hFF) && (shadow_high_sum_reg != 8'hFF),
        "checksum sum left unreduced")

    // Section and gap starts never run ahead of the offset counter.
    `SSF_ASSERT(a_start_order, clk, rst_n,
        (current_start_reg <= byte_offset_reg) && (gap_begin_reg <= byte_offset_reg),
        "section or gap start beyond byte offset")

    // A reporting word may not advance into a blocked output register.
    `SSF_ASSERT(a_no_overwrite, clk, rst_n,
        (out_valid_reg && !out_ch.ready && emit) |-> !s1_adv,
        "report overwrote a pending output word")

    // End of stream returns the stream state to reset values.
    `SSF_ASSERT(a_end_clears, clk, rst_n,
        (s1_adv && (s1_cmd_reg == ssf16_pkg::CMD_END)) |=>
            ((byte_offset_reg == '0) && (zero_run_count_reg == '0) && !overflow_seen_reg),
        "stream state not cleared after end of input")

endmodule

`default_nettype wire
